// ----- rtl/lfp_pkg.sv -----
// Shared constants for the lidar frame parser.
`timescale 1ns / 1ps

package lfp_pkg;

	localparam int BYTE_W   = 8;
	localparam int HIGH_W   = 6;
	localparam int DIST_W   = BYTE_W + HIGH_W;
	localparam int ANGLE_W  = 7;
	localparam int NUM_DIST = 4;

	localparam int FRAME_LEN = 22;
	localparam int POS_W     = $clog2(FRAME_LEN);

	localparam logic [POS_W-1:0] SYNC_POS  = POS_W'(0);
	localparam logic [POS_W-1:0] INDEX_POS = POS_W'(1);
	localparam logic [POS_W-1:0] LAST_POS  = POS_W'(FRAME_LEN - 1);

	// Distance k: low byte at FIRST_LOW_POS + k*DIST_STRIDE, high part one byte later.
	localparam int FIRST_LOW_POS = 5;
	localparam int DIST_STRIDE   = 4;

	localparam logic [BYTE_W-1:0] SYNC_BYTE  = 8'hFA;
	localparam logic [BYTE_W-1:0] INDEX_MIN  = 8'hA0;
	localparam logic [BYTE_W-1:0] INDEX_MAX  = 8'hF9;
	localparam logic [BYTE_W-1:0] INDEX_BASE = 8'h9F;

endpackage

// ----- rtl/lfp_intf.sv -----
// Valid/ready channel interfaces for received bytes and parsed frames.
`timescale 1ns / 1ps

interface lfp_byte_if;
	logic                      valid;
	logic                      ready;
	logic [lfp_pkg::BYTE_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface lfp_frame_if;
	logic                       valid;
	logic                       ready;
	logic [lfp_pkg::ANGLE_W-1:0] angle_index;
	logic [lfp_pkg::DIST_W-1:0]  distance_first;
	logic [lfp_pkg::DIST_W-1:0]  distance_second;
	logic [lfp_pkg::DIST_W-1:0]  distance_third;
	logic [lfp_pkg::DIST_W-1:0]  distance_fourth;

	modport source (
		output valid, output angle_index, output distance_first, output distance_second,
		output distance_third, output distance_fourth, input ready
	);
	modport sink (
		input valid, input angle_index, input distance_first, input distance_second,
		input distance_third, input distance_fourth, output ready
	);
endinterface

// ----- rtl/lidar_frame_parser_core.sv -----
// Lidar frame parser: assembles 22-byte frames and emits angle index and four distances.
`timescale 1ns / 1ps

// Takes one received byte per beat on rx and returns one beat on frame for every complete
// 22-byte frame. Byte 0 must be 0xFA or it is dropped; byte 1 must be an index in
// 0xA0..0xF9 or the frame is abandoned (that byte is never retried as a sync byte). Each
// distance is a low byte plus the low six bits of the next byte (bytes 5/6, 9/10, 13/14,
// 17/18); angle_index is the index byte minus 0x9F. No checksum is checked. One byte is
// taken every cycle: the frame state updates in the accepting cycle and the result lands
// in an output register, so rx stalls only while that register holds a beat the sink has
// not taken. A result appears in the cycle after byte 21 is accepted.
module lidar_frame_parser_core (
	input  logic            clk,
	input  logic            arst_n,
	lfp_byte_if.sink        rx,
	lfp_frame_if.source     frame
);

	logic [lfp_pkg::POS_W-1:0]  pos_q;
	logic [lfp_pkg::BYTE_W-1:0] index_q;
	logic [lfp_pkg::BYTE_W-1:0] dist_lo_q [lfp_pkg::NUM_DIST];
	logic [lfp_pkg::HIGH_W-1:0] dist_hi_q [lfp_pkg::NUM_DIST];

	logic                        out_valid_q;
	logic [lfp_pkg::ANGLE_W-1:0] angle_q;
	logic [lfp_pkg::DIST_W-1:0]  dist_out_q [lfp_pkg::NUM_DIST];

	logic                        accept;
	logic                        index_ok;
	logic [lfp_pkg::POS_W-1:0]   pos_next;
	logic [lfp_pkg::BYTE_W-1:0]  angle_full;

	assign rx.ready = !out_valid_q || frame.ready;
	assign accept   = rx.valid && rx.ready;
	assign index_ok = (rx.rx_byte >= lfp_pkg::INDEX_MIN) && (rx.rx_byte <= lfp_pkg::INDEX_MAX);
	assign angle_full = index_q - lfp_pkg::INDEX_BASE;

	always_comb begin
		if (pos_q == lfp_pkg::SYNC_POS) begin
			pos_next = (rx.rx_byte == lfp_pkg::SYNC_BYTE) ? lfp_pkg::INDEX_POS : lfp_pkg::SYNC_POS;
		end else if (pos_q == lfp_pkg::INDEX_POS) begin
			pos_next = index_ok ? lfp_pkg::POS_W'(2) : lfp_pkg::SYNC_POS;
		end else if (pos_q == lfp_pkg::LAST_POS) begin
			pos_next = lfp_pkg::SYNC_POS;
		end else begin
			pos_next = pos_q + lfp_pkg::POS_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= lfp_pkg::SYNC_POS;
		end else if (accept) begin
			pos_q <= pos_next;
		end
	end

	// Frame payload holds; written only at their own byte positions.
	always_ff @(posedge clk) begin
		if (accept) begin
			if (pos_q == lfp_pkg::INDEX_POS) begin
				index_q <= rx.rx_byte;
			end
			for (int k = 0; k < lfp_pkg::NUM_DIST; k++) begin
				if (pos_q == lfp_pkg::POS_W'(lfp_pkg::FIRST_LOW_POS + k * lfp_pkg::DIST_STRIDE)) begin
					dist_lo_q[k] <= rx.rx_byte;
				end
				if (pos_q == lfp_pkg::POS_W'(lfp_pkg::FIRST_LOW_POS + k * lfp_pkg::DIST_STRIDE + 1)) begin
					dist_hi_q[k] <= rx.rx_byte[lfp_pkg::HIGH_W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && pos_q == lfp_pkg::LAST_POS) begin
			out_valid_q <= 1'b1;
		end else if (frame.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && pos_q == lfp_pkg::LAST_POS) begin
			angle_q <= angle_full[lfp_pkg::ANGLE_W-1:0];
			for (int k = 0; k < lfp_pkg::NUM_DIST; k++) begin
				dist_out_q[k] <= {dist_hi_q[k], dist_lo_q[k]};
			end
		end
	end

	assign frame.valid           = out_valid_q;
	assign frame.angle_index     = angle_q;
	assign frame.distance_first  = dist_out_q[0];
	assign frame.distance_second = dist_out_q[1];
	assign frame.distance_third  = dist_out_q[2];
	assign frame.distance_fourth = dist_out_q[3];

`ifndef SYNTHESIS
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= lfp_pkg::LAST_POS)
		else $error("frame position out of range");

	a_result_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && pos_q == lfp_pkg::LAST_POS) |=> (frame.valid && pos_q == lfp_pkg::SYNC_POS))
		else $error("no result after last frame byte");

	a_bad_sync_stays: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && pos_q == lfp_pkg::SYNC_POS && rx.rx_byte != lfp_pkg::SYNC_BYTE)
		|=> (pos_q == lfp_pkg::SYNC_POS))
		else $error("bad sync byte advanced the frame");

	a_index_held_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(pos_q != lfp_pkg::SYNC_POS && pos_q != lfp_pkg::INDEX_POS)
		|-> (index_q >= lfp_pkg::INDEX_MIN && index_q <= lfp_pkg::INDEX_MAX))
		else $error("frame in progress with invalid index");
`endif

endmodule
